/* hdl/pei_pkg.sv */
// Shared constants and types for the polynomial easing interpolator.
`default_nettype none

package pei_pkg;

    localparam int FB   = 10;
    localparam int UW   = FB + 1;
    localparam int U2W  = 2 * FB + 1;
    localparam int U3W  = 3 * FB + 1;
    localparam int U4W  = 4 * FB + 1;
    localparam int LOW  = 2 * FB + 1;
    localparam int HIW  = 2 * FB;
    localparam int U5W  = 5 * FB + 2;
    localparam int DW   = 17;
    localparam int PRW  = UW + 1 + DW;
    localparam int NST  = FB + 7;
    localparam int LAT  = FB + 8;

    localparam logic [UW-1:0] RANGE = UW'(1) << FB;

    localparam logic [3:0] OP_LINEAR      = 4'd0;
    localparam logic [3:0] OP_QUAD_IN     = 4'd1;
    localparam logic [3:0] OP_QUAD_OUT    = 4'd2;
    localparam logic [3:0] OP_QUAD_INOUT  = 4'd3;
    localparam logic [3:0] OP_CUBIC_IN    = 4'd4;
    localparam logic [3:0] OP_CUBIC_OUT   = 4'd5;
    localparam logic [3:0] OP_CUBIC_INOUT = 4'd6;
    localparam logic [3:0] OP_QUINT_IN    = 4'd7;
    localparam logic [3:0] OP_QUINT_OUT   = 4'd8;
    localparam logic [3:0] OP_QUINT_INOUT = 4'd9;

    typedef enum logic [1:0] {
        PW_2 = 2'd0,
        PW_3 = 2'd1,
        PW_5 = 2'd2
    } pwr_t;

    typedef struct packed {
        logic                valid;
        logic                lin;
        logic                outm;
        pwr_t                pw;
        logic signed [15:0]  s;
        logic signed [DW-1:0] diff;
        logic [FB-1:0]       ph;
    } ctl_t;

endpackage

`default_nettype wire

/* hdl/polynomial_easing_interpolator.sv */
// Top level: pipelined polynomial easing interpolator.
`default_nettype none

// Fully pipelined: one request per cycle, busy is always low. The result
// strobe done marks pos valid once the request has passed through every
// pipeline register in turn: one decode stage, one restoring-divider stage
// per phase bit, five stages of power products, one scaling multiply and
// the output register. The receiver cannot stall; every request gives
// exactly one result.
module polynomial_easing_interpolator
    import pei_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [3:0]         op,
    input  wire logic signed [15:0] start_pos,
    input  wire logic signed [15:0] end_pos,
    input  wire logic [15:0]        cur_time,
    input  wire logic [15:0]        duration,
    output logic                    done,
    output logic signed [15:0]      pos
);

    ctl_t ctl_reg [NST];
    ctl_t ctl_next [NST];
    logic [15:0] rem_reg [FB];
    logic [15:0] rem_next [FB];
    logic [15:0] den_reg [FB];

    logic [UW-1:0]  u_reg, ua_reg, ub_reg;
    logic [U2W-1:0] u2_reg, u2b_reg;
    logic [U3W-1:0] u3_reg;
    logic [U4W-1:0] u4_reg;
    logic [3*FB+1:0] lo_reg;
    logic [3*FB:0]   hi_reg;
    logic [UW-1:0]  pw_reg, x_reg, x_next, base;
    logic [U5W-1:0] u5;
    logic signed [PRW-1:0] prod_reg;
    logic signed [PRW-1:0] sh;
    logic signed [15:0] pos_reg;
    logic               done_reg;

    // decode
    logic               lin, outm, inout_m;
    pwr_t               pw;
    logic [14:0]        half;
    logic signed [15:0] mid, seg_s, seg_e;
    logic [15:0]        seg_t, seg_d;
    logic               fin;

    assign busy = 1'b0;

    always_comb
    begin
        logic [16:0] r2;
        logic        ge;
        lin = 1'b0;
        outm = 1'b0;
        inout_m = 1'b0;
        pw = PW_2;
        unique case (op)
            OP_QUAD_IN:
            begin
                pw = PW_2;
            end
            OP_QUAD_OUT:
            begin
                pw = PW_2;
                outm = 1'b1;
            end
            OP_QUAD_INOUT:
            begin
                pw = PW_2;
                inout_m = 1'b1;
            end
            OP_CUBIC_IN:
            begin
                pw = PW_3;
            end
            OP_CUBIC_OUT:
            begin
                pw = PW_3;
                outm = 1'b1;
            end
            OP_CUBIC_INOUT:
            begin
                pw = PW_3;
                inout_m = 1'b1;
            end
            OP_QUINT_IN:
            begin
                pw = PW_5;
            end
            OP_QUINT_OUT:
            begin
                pw = PW_5;
                outm = 1'b1;
            end
            OP_QUINT_INOUT:
            begin
                pw = PW_5;
                inout_m = 1'b1;
            end
            default:
            begin
                lin = 1'b1;
            end
        endcase

        half = duration[15:1];
        mid = (end_pos >>> 1) + (start_pos >>> 1);
        seg_s = start_pos;
        seg_e = end_pos;
        seg_t = cur_time;
        seg_d = duration;
        if (inout_m)
        begin
            seg_d = {1'b0, half};
            if (cur_time < {1'b0, half})
            begin
                seg_e = mid;
                outm = 1'b0;
            end
            else
            begin
                seg_s = mid;
                seg_t = cur_time - {1'b0, half};
                outm = 1'b1;
            end
        end
        fin = (seg_t >= seg_d);

        ctl_next[0].valid = start;
        ctl_next[0].lin   = lin;
        ctl_next[0].outm  = outm;
        ctl_next[0].pw    = pw;
        // finished segment: hold end position with zero span
        ctl_next[0].s     = fin ? seg_e : seg_s;
        ctl_next[0].diff  = fin ? '0 : (DW'(seg_e) - DW'(seg_s));
        ctl_next[0].ph    = '0;
        rem_next[0]       = fin ? 16'd0 : seg_t;

        // one quotient bit per stage
        for (int j = 1; j <= FB; j++)
        begin
            r2 = {rem_reg[j-1], 1'b0};
            ge = (r2 >= {1'b0, den_reg[j-1]});
            if (j < FB)
            begin
                rem_next[j] = ge ? 16'(r2 - {1'b0, den_reg[j-1]}) : r2[15:0];
            end
            ctl_next[j] = ctl_reg[j-1];
            ctl_next[j].ph = {ctl_reg[j-1].ph[FB-2:0], ge};
        end
        for (int j = FB + 1; j < NST; j++)
        begin
            ctl_next[j] = ctl_reg[j-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NST; j++)
            begin
                ctl_reg[j] <= '0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < NST; j++)
            begin
                ctl_reg[j] <= ctl_next[j];
            end
            done_reg <= ctl_reg[NST-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < FB; j++)
        begin
            rem_reg[j] <= rem_next[j];
        end
        den_reg[0] <= (seg_t >= seg_d) ? 16'd1 : seg_d;
        for (int j = 1; j < FB; j++)
        begin
            den_reg[j] <= den_reg[j-1];
        end
    end

    // power products
    always_comb
    begin
        u5 = (U5W'(hi_reg) << LOW) + U5W'(lo_reg);
        base = (ctl_reg[FB+4].pw == PW_5) ? u5[5*FB:4*FB] : pw_reg;
        if (ctl_reg[FB+4].lin)
            x_next = {1'b0, ctl_reg[FB+4].ph};
        else if (ctl_reg[FB+4].outm)
            x_next = RANGE - base;
        else
            x_next = base;
        sh = prod_reg >>> FB;
    end

    always_ff @(posedge clk)
    begin
        u_reg  <= ctl_reg[FB].outm ? (RANGE - {1'b0, ctl_reg[FB].ph})
                                   : {1'b0, ctl_reg[FB].ph};
        u2_reg <= U2W'(u_reg) * U2W'(u_reg);
        ua_reg <= u_reg;
        u2b_reg <= u2_reg;
        u3_reg <= U3W'(u2_reg) * U3W'(ua_reg);
        u4_reg <= U4W'(u2_reg) * U4W'(u2_reg);
        ub_reg <= ua_reg;
        lo_reg <= (3*FB+2)'(u4_reg[LOW-1:0]) * (3*FB+2)'(ub_reg);
        hi_reg <= (3*FB+1)'(u4_reg[U4W-1:LOW]) * (3*FB+1)'(ub_reg);
        pw_reg <= (ctl_reg[FB+3].pw == PW_2) ? u2b_reg[2*FB:FB]
                                             : u3_reg[3*FB:2*FB];
        x_reg  <= x_next;
        prod_reg <= PRW'($signed({1'b0, x_reg})) * PRW'(ctl_reg[FB+5].diff);
        pos_reg  <= sh[15:0] + ctl_reg[FB+6].s;
    end

    assign done = done_reg;
    assign pos  = pos_reg;

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ##LAT (done == $past(start && !busy, LAT)))
        else $error("result strobe out of step with requests");

    a_zero_dur: assert property (@(posedge clk) disable iff (!rst_n)
        (start && duration == 16'd0) |-> ##LAT (pos == $past(end_pos, LAT)))
        else $error("zero duration must give end position");

endmodule

`default_nettype wire

/* bench/polynomial_easing_interpolator_tb.sv */
// Self-checking testbench for the polynomial easing interpolator.
`timescale 1ns / 100ps

module polynomial_easing_interpolator_tb;
    import pei_pkg::*;

    localparam int N_RANDOM  = 1250;
    localparam int CYC_LIMIT = 400000;

    // Easing math shared by the scoreboard; returns the wrapped position.
    function automatic logic signed [15:0] eased_pos(logic [3:0] code,
        logic signed [15:0] s16, logic signed [15:0] e16, logic [15:0] t16,
        logic [15:0] d16);
        longint s, e, t, d, half, mid, x, ph, rng, pw, acc, tt;
        int n, mode;
        longint r;
        s = s16;
        e = e16;
        t = t16;
        d = d16;
        rng = 64'd1 << FB;
        n = 1;
        mode = 0;
        if (code >= OP_QUAD_IN && code <= OP_QUINT_INOUT)
        begin
            n = (code <= OP_QUAD_INOUT) ? 2 : (code <= OP_CUBIC_INOUT) ? 3 : 5;
            mode = (code - 1) % 3;
        end
        tt = t;
        if (mode == 2)
        begin
            half = d >>> 1;
            mid = (e >>> 1) + (s >>> 1);
            if (t < half)
            begin
                e = mid;
                mode = 0;
            end
            else
            begin
                s = mid;
                tt = t - half;
                mode = 1;
            end
            d = half;
        end
        if (tt >= d)
        begin
            r = e;
        end
        else
        begin
            ph = (tt << FB) / d;
            if (n == 1)
            begin
                x = ph;
            end
            else
            begin
                acc = (mode == 0) ? ph : rng - ph;
                pw = 1;
                for (int i = 0; i < n; i++)
                    pw = pw * acc;
                pw = pw >> ((n - 1) * FB);
                x = (mode == 0) ? pw : rng - pw;
            end
            r = ((x * (e - s)) >>> FB) + s;
        end
        return r[15:0];
    endfunction

    class pos_scoreboard;
        logic signed [15:0] pending_pos[$];
        int errors;

        function void note_request(logic [3:0] code, logic signed [15:0] s,
            logic signed [15:0] e, logic [15:0] t, logic [15:0] d);
            pending_pos.push_back(eased_pos(code, s, e, t, d));
        endfunction

        function void check_pos(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending_pos.size() == 0)
            begin
                $error("unexpected result: pos=%0d", got);
                errors++;
                return;
            end
            want = pending_pos.pop_front();
            if (got !== want)
            begin
                $error("pos mismatch: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [3:0]         op;
    logic signed [15:0] start_pos;
    logic signed [15:0] end_pos;
    logic [15:0]        cur_time;
    logic [15:0]        duration;
    logic               done;
    logic signed [15:0] pos;

    pos_scoreboard sb;
    int cycles;
    int idle_pct;

    polynomial_easing_interpolator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .start_pos (start_pos),
        .end_pos   (end_pos),
        .cur_time  (cur_time),
        .duration  (duration),
        .done      (done),
        .pos       (pos)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            sb.check_pos(pos);
        if (cycles > CYC_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Present one request; hold start until it is taken.
    task automatic send_request(logic [3:0] code, logic signed [15:0] s,
        logic signed [15:0] e, logic [15:0] t, logic [15:0] d);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        op        <= code;
        start_pos <= s;
        end_pos   <= e;
        cur_time  <= t;
        duration  <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(code, s, e, t, d);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_pos.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random();
        logic [3:0]  code;
        logic [15:0] d, t;
        code = 4'($urandom_range(15));
        if (code > OP_QUINT_INOUT && $urandom_range(3) != 0)
            code = 4'($urandom_range(OP_QUINT_INOUT));
        case ($urandom_range(3))
            0: d = 16'($urandom_range(8));
            1: d = 16'($urandom_range(300));
            default: d = 16'($urandom);
        endcase
        case ($urandom_range(5))
            0: t = d;
            1: t = 16'($urandom);
            2: t = d >> 1;
            default: t = (d == 0) ? 16'd0 : 16'($urandom_range(d - 1));
        endcase
        send_request(code, 16'($urandom), 16'($urandom), t, d);
    endtask

    initial
    begin
        sb = new();
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_LINEAR;
        start_pos = '0;
        end_pos = '0;
        cur_time = '0;
        duration = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every curve at one phase, plus the edge cases.
        for (int c = OP_LINEAR; c <= OP_QUINT_INOUT; c++)
            send_request(c[3:0], -16'sd32768, 16'sd32767, 16'd333, 16'd1000);
        send_request(OP_QUAD_OUT, 16'sd32767, -16'sd32768, 16'd65534, 16'hFFFF);
        send_request(OP_CUBIC_IN, 16'sd100, -16'sd100, 16'd0, 16'd0);
        send_request(OP_LINEAR, 16'sd5, 16'sd9, 16'hFFFF, 16'd3);
        send_request(OP_QUINT_INOUT, 16'sd7, -16'sd9, 16'd0, 16'd1);
        send_request(OP_QUAD_INOUT, -16'sd3, 16'sd11, 16'd2, 16'd5);
        send_request(OP_CUBIC_INOUT, 16'sd32767, -16'sd32768, 16'd1, 16'd2);
        send_request(4'd15, -16'sd1, 16'sd32767, 16'd1, 16'd2);
        send_request(4'd10, 16'sd0, -16'sd1, 16'd0, 16'd1);
        send_request(OP_QUINT_OUT, -16'sd32768, 16'sd32767, 16'd1, 16'hFFFF);
        drain();

        idle_pct = 16;
        for (int i = 0; i < N_RANDOM / 2; i++)
            send_random();
        // Hold off until the pipeline is empty.
        drain();
        idle_pct = 59;
        for (int i = 0; i < N_RANDOM / 4; i++)
            send_random();
        idle_pct = 0;
        for (int i = 0; i < N_RANDOM / 4; i++)
            send_random();
        drain();
        repeat (LAT + 10) @(posedge clk);

        if (sb.errors == 0 && sb.pending_pos.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/pei_pkg.sv
hdl/polynomial_easing_interpolator.sv
bench/polynomial_easing_interpolator_tb.sv
